// ----- rtl/core/polyline_normal_offset_unit_defines.svh -----
// ----------------------------------------------------------------------------
// polyline normal offset unit - assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef POLYLINE_NORMAL_OFFSET_UNIT_DEFINES_SVH
`define POLYLINE_NORMAL_OFFSET_UNIT_DEFINES_SVH

// condition must hold on every clock edge out of reset
`define PNO_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent on an edge implies consequent on the same edge
`define PNO_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/pno_pkg.sv -----
// ----------------------------------------------------------------------------
// pno_pkg
// widths, codes and types of the polyline normal offset unit
// ----------------------------------------------------------------------------
`default_nettype none

package pno_pkg;

  localparam int COORD_W  = 32;              // coordinate width, Q16.16
  localparam int TAN_W    = COORD_W + 1;     // exact difference of two coordinates
  localparam int TW_W     = 21;              // track width register
  localparam int NORM_MSB = 29;              // normalized magnitude lies in [2^29, 2^30)
  localparam int MAG_W    = NORM_MSB + 1;    // normalized magnitude width
  localparam int PROD_W   = 2 * MAG_W;       // multiplier product
  localparam int SUMSQ_W  = PROD_W + 1;      // sum of two squares
  localparam int RAD_W    = 2 * (MAG_W + 1); // radicand, even width
  localparam int ROOT_W   = RAD_W / 2;       // square root result
  localparam int REM_W    = ROOT_W + 1;      // shared remainder register
  localparam int SUB_W    = REM_W + 2;       // shared subtractor operands
  localparam int QUO_W    = TW_W;            // quotient never exceeds track width
  localparam int NUM_W    = TW_W + MAG_W + 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W    = 5;

  localparam logic [TW_W-1:0] TW_RESET = TW_W'(229376);

  // configuration register indexes
  localparam logic CFG_OFFSET_WIDTH = 1'b0;
  localparam logic CFG_LANE_SIDE    = 1'b1;

  // points held for the current polyline
  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_MANY = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TAN_W-1:0]   tan_t;

endpackage

`default_nettype wire

// ----- rtl/core/polyline_normal_offset_unit.sv -----
// ----------------------------------------------------------------------------
// polyline_normal_offset_unit
// parallel offset of a lane polyline along the unit normal of its tangent
// ----------------------------------------------------------------------------
// usage
//   points arrive on the in_valid/in_ready channel, one item per point, with
//   final_point set on the last point of a polyline. results leave on the
//   out_valid/out_ready channel. results lag one point: the first point gives
//   none unless it is also final, each later point gives the result for the
//   point before it, and the final point also gives its own result, marked end_of_lane.
//   offset_width and lane_side are written on the cfg channel while idle;
//   cfg_ready is always high.
//   datapath: each result goes through one shared multiplier and one shared
//   subtractor, in order: load, normalizing shift, the two squares and their
//   sum, the square root, then for x and then y a product, a divider load and
//   a division, and the finish step. the next item is taken only once the
//   sequencer is back in idle. a final point runs two such jobs in turn; a
//   zero tangent goes from the load step straight to the finish step; a first
//   point makes no result and leaves in_ready high.
//   in_ready is high only while the sequencer is idle.
//   the result sits in an output register, so a stalled receiver holds only
//   that register: the next item is still taken and worked on, and the
//   sequencer waits at its last step until the register is free.
//   reset restores offset width 3.5 m, lane_side 0, no points held and no
//   result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_normal_offset_unit_defines.svh"

module polyline_normal_offset_unit
  import pno_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [TW_W-1:0]      cfg_data,
  // points in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   point_x,
  input  logic [COORD_W-1:0]   point_y,
  input  logic                 final_point,
  // offset points out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   offset_x,
  output logic [COORD_W-1:0]   offset_y,
  output logic                 dropped,
  output logic                 end_of_lane
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;  // take magnitudes of the tangent
  localparam logic [3:0] ST_NORM  = 4'd2;  // shift magnitudes into range
  localparam logic [3:0] ST_MULA  = 4'd3;  // ax * ax
  localparam logic [3:0] ST_MULB  = 4'd4;  // ay * ay
  localparam logic [3:0] ST_SUM   = 4'd5;  // radicand
  localparam logic [3:0] ST_SQRT  = 4'd6;  // one root bit per cycle
  localparam logic [3:0] ST_MULX  = 4'd7;  // offset_width * ax
  localparam logic [3:0] ST_DIVLD = 4'd8;  // add rounding half, load divider
  localparam logic [3:0] ST_DIV   = 4'd9;  // one quotient bit per cycle
  localparam logic [3:0] ST_MULY  = 4'd10; // offset_width * ay
  localparam logic [3:0] ST_FIN   = 4'd11; // apply offset, saturate, hand over

  logic [3:0]          state;
  logic [CNT_W-1:0]    cnt;

  // configuration
  logic [TW_W-1:0]     offset_width;
  logic                lane_side;

  // polyline history
  logic [1:0]          points_seen;
  coord_t              prev_x, prev_y, older_x, older_y;

  // current job and the pending job of a final point
  coord_t              jb_x, jb_y;
  tan_t                jt_x, jt_y;
  logic                j_end;
  coord_t              pd_x, pd_y;
  tan_t                pdt_x, pdt_y;
  logic                pend_valid;

  // datapath
  logic [TAN_W-1:0]    ax, ay;
  logic [TAN_W-1:0]    mag_or;
  logic                drop;
  logic                div_y;
  logic [PROD_W-1:0]   prod;
  logic [SUMSQ_W-1:0]  sumsq;
  logic [RAD_W-1:0]    rad;
  logic [ROOT_W-1:0]   root;
  logic [REM_W-1:0]    rem;
  logic [QUO_W-1:0]    dq;
  logic [QUO_W-1:0]    qx, qy;

  // shared multiplier operands
  logic [MAG_W-1:0]    mul_a, mul_b;

  // shared subtractor
  logic [SUB_W-1:0]    sub_a, sub_b;
  logic [SUB_W:0]      sub_diff;
  logic                sub_ge;

  // accept side
  logic                in_fire;
  coord_t              px, py, sel_x, sel_y;
  logic [NUM_W-1:0]    num;
  logic [SUMSQ_W-1:0]  rad_sum;
  coord_t              res_x, res_y;

  function automatic tan_t tan_diff(input coord_t a, input coord_t b);
    tan_diff = TAN_W'(a) - TAN_W'(b);
  endfunction

  function automatic logic [TAN_W-1:0] mag_of(input tan_t t);
    mag_of = t[TAN_W-1] ? TAN_W'(-t) : TAN_W'(t);
  endfunction

  // base + or - q, clamped to the coordinate range
  function automatic coord_t offset_sat(input coord_t base, input logic [QUO_W-1:0] q,
                                        input logic neg);
    logic [COORD_W+1:0] bext;
    logic [COORD_W+1:0] qext;
    logic [COORD_W+1:0] s;
    bext = {{2{base[COORD_W-1]}}, base};
    qext = (COORD_W + 2)'(q);
    s    = neg ? bext - qext : bext + qext;
    if (s[COORD_W+1:COORD_W-1] == 3'b000 || s[COORD_W+1:COORD_W-1] == 3'b111) begin
      offset_sat = coord_t'(s[COORD_W-1:0]);
    end else if (s[COORD_W+1]) begin
      offset_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      offset_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign px        = coord_t'(point_x);
  assign py        = coord_t'(point_y);

  // interior tangent spans two points, the first one-sided
  assign sel_x = (points_seen == PS_ONE) ? prev_x : older_x;
  assign sel_y = (points_seen == PS_ONE) ? prev_y : older_y;

  assign mag_or = ax | ay;

  always_comb begin
    case (state)
      ST_MULA: begin
        mul_a = ax[MAG_W-1:0];
        mul_b = ax[MAG_W-1:0];
      end
      ST_MULB: begin
        mul_a = ay[MAG_W-1:0];
        mul_b = ay[MAG_W-1:0];
      end
      ST_MULX: begin
        mul_a = MAG_W'(offset_width);
        mul_b = ax[MAG_W-1:0];
      end
      default: begin
        mul_a = MAG_W'(offset_width);
        mul_b = ay[MAG_W-1:0];
      end
    endcase
  end

  // root step compares against 4*root+1, divide step against the length
  always_comb begin
    if (state == ST_SQRT) begin
      sub_a = {rem, rad[RAD_W-1 -: 2]};
      sub_b = {1'b0, root, 2'b01};
    end else begin
      sub_a = {2'b00, rem[ROOT_W-1:0], dq[QUO_W-1]};
      sub_b = {3'b000, root};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = !sub_diff[SUB_W];
  end

  assign rad_sum = sumsq + SUMSQ_W'(prod);
  assign num     = NUM_W'(prod[NUM_W-2:0]) + NUM_W'(root[ROOT_W-1:1]);

  // x moves with ty, y with tx; side picks the normal's direction
  assign res_x = offset_sat(jb_x, qy, jt_y[TAN_W-1] ^ lane_side);
  assign res_y = offset_sat(jb_y, qx, !(jt_x[TAN_W-1] ^ lane_side));

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_width <= TW_RESET;
      lane_side    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OFFSET_WIDTH: offset_width <= cfg_data;
        CFG_LANE_SIDE:    lane_side    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      points_seen <= PS_NONE;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // the finish step owns out_valid when it hands over a result
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (points_seen == PS_NONE) begin
              if (final_point) begin
                // lone point: zero tangent, dropped and end of lane
                jt_x  <= '0;
                jt_y  <= '0;
                j_end <= 1'b1;
                state <= ST_LOAD;
              end else begin
                prev_x      <= px;
                prev_y      <= py;
                points_seen <= PS_ONE;
              end
            end else begin
              jb_x  <= prev_x;
              jb_y  <= prev_y;
              jt_x  <= tan_diff(px, sel_x);
              jt_y  <= tan_diff(py, sel_y);
              j_end <= 1'b0;
              state <= ST_LOAD;
              if (final_point) begin
                pd_x        <= px;
                pd_y        <= py;
                pdt_x       <= tan_diff(px, prev_x);
                pdt_y       <= tan_diff(py, prev_y);
                pend_valid  <= 1'b1;
                points_seen <= PS_NONE;
              end else begin
                older_x     <= prev_x;
                older_y     <= prev_y;
                prev_x      <= px;
                prev_y      <= py;
                points_seen <= PS_MANY;
              end
            end
          end
        end
        ST_LOAD: begin
          ax    <= mag_of(jt_x);
          ay    <= mag_of(jt_y);
          drop  <= (jt_x == '0) && (jt_y == '0);
          div_y <= 1'b0;
          state <= ((jt_x == '0) && (jt_y == '0)) ? ST_FIN : ST_NORM;
        end
        ST_NORM: begin
          if (mag_or[TAN_W-1:NORM_MSB+1] != '0) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
          end else if (mag_or[TAN_W-1:NORM_MSB-8] == '0) begin
            ax <= ax << 8;
            ay <= ay << 8;
          end else if (!mag_or[NORM_MSB]) begin
            ax <= ax << 1;
            ay <= ay << 1;
          end else begin
            state <= ST_MULA;
          end
        end
        ST_MULA: begin
          prod  <= mul_a * mul_b;
          state <= ST_MULB;
        end
        ST_MULB: begin
          prod  <= mul_a * mul_b;
          sumsq <= SUMSQ_W'(prod);
          state <= ST_SUM;
        end
        ST_SUM: begin
          rad   <= RAD_W'(rad_sum);
          rem   <= '0;
          root  <= '0;
          cnt   <= CNT_W'(SQRT_STEPS - 1);
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          rem  <= sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
          root <= {root[ROOT_W-2:0], sub_ge};
          rad  <= {rad[RAD_W-3:0], 2'b00};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_MULX;
          end
        end
        ST_MULX: begin
          prod  <= mul_a * mul_b;
          state <= ST_DIVLD;
        end
        ST_MULY: begin
          prod  <= mul_a * mul_b;
          div_y <= 1'b1;
          state <= ST_DIVLD;
        end
        ST_DIVLD: begin
          // quotient fits QUO_W bits, so the top part is already below len
          rem   <= REM_W'(num[NUM_W-1:QUO_W]);
          dq    <= num[QUO_W-1:0];
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
          dq  <= {dq[QUO_W-2:0], sub_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (div_y) begin
              qy    <= {dq[QUO_W-2:0], sub_ge};
              state <= ST_FIN;
            end else begin
              qx    <= {dq[QUO_W-2:0], sub_ge};
              state <= ST_MULY;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            offset_x    <= drop ? '0 : res_x;
            offset_y    <= drop ? '0 : res_y;
            dropped     <= drop;
            end_of_lane <= j_end;
            if (pend_valid) begin
              // final point's own result follows
              jb_x       <= pd_x;
              jb_y       <= pd_y;
              jt_x       <= pdt_x;
              jt_y       <= pdt_y;
              j_end      <= 1'b1;
              pend_valid <= 1'b0;
              state      <= ST_LOAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a dropped result always carries zero offsets
  `PNO_ASSERT_IMPLIES(a_drop_zero, out_valid && dropped, offset_x == '0 && offset_y == '0, "dropped result with nonzero offset")
  // normalized magnitudes sit in [2^29, 2^30) when the squares start
  `PNO_ASSERT_IMPLIES(a_norm_range, state == ST_MULA, mag_or[TAN_W-1:NORM_MSB+1] == '0 && mag_or[NORM_MSB], "magnitudes out of range after normalize")
  // root of a normalized radicand is at least 2^29
  `PNO_ASSERT_IMPLIES(a_len_range, state == ST_MULX, root[ROOT_W-1:NORM_MSB] != '0, "tangent length below normalized range")
  // a second result is pending only while a job is being worked on
  `PNO_ASSERT_IMPLIES(a_pend_busy, pend_valid, state != ST_IDLE, "pending final result while idle")

endmodule

`default_nettype wire

// ----- tb/polyline_normal_offset_unit_checker.sv -----
// ----------------------------------------------------------------------------
// polyline normal offset unit - result checker
// follows the cfg, point and offset channels, predicts the offset points
// of each accepted item and compares every result field by field
// ----------------------------------------------------------------------------
module polyline_normal_offset_unit_checker
  import pno_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [TW_W-1:0]    cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [COORD_W-1:0] point_x,
  input  logic [COORD_W-1:0] point_y,
  input  logic               final_point,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [COORD_W-1:0] offset_x,
  input  logic [COORD_W-1:0] offset_y,
  input  logic               dropped,
  input  logic               end_of_lane,
  output int                 mismatch_count,
  output int                 pending_results,
  output int                 results_seen,
  output int                 drops_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;
    logic               drop;
    logic               eol;
  } offset_result_t;

  offset_result_t expected_offsets[$];

  // predictor copy of registers and held points
  logic [TW_W-1:0] width_reg;
  logic            side_reg;
  logic [1:0]      held_count;
  longint          held_x, held_y, back_x, back_y;

  // append one predicted result at the tail of the queue
  function automatic void add_expected(input offset_result_t r);
    expected_offsets.insert(expected_offsets.size(), r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v    -= root + bit_w;
        root  = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (COORD_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return COORD_W'(hi);
    if (v < lo) return COORD_W'(lo);
    return COORD_W'(v);
  endfunction

  // point moved by track width along the unit normal of tangent (tx,ty)
  function automatic offset_result_t offset_along_normal(longint px, longint py,
                                                        longint tx, longint ty,
                                                        logic last);
    offset_result_t  r;
    longint unsigned ax, ay, mag, len, qx, qy;
    longint          cx, cy, ox, oy;
    r.off_x = '0;
    r.off_y = '0;
    r.drop  = 1'b0;
    r.eol   = last;
    if (tx == 0 && ty == 0) begin
      r.drop = 1'b1;
      return r;
    end
    ax  = (tx < 0) ? -tx : tx;
    ay  = (ty < 0) ? -ty : ty;
    mag = (ax > ay) ? ax : ay;
    while (mag >= (64'd1 << (NORM_MSB + 1))) begin
      ax >>= 1; ay >>= 1; mag >>= 1;
    end
    while (mag < (64'd1 << NORM_MSB)) begin
      ax <<= 1; ay <<= 1; mag <<= 1;
    end
    len = int_sqrt(ax * ax + ay * ay);
    qx  = (width_reg * ax + len / 2) / len;
    qy  = (width_reg * ay + len / 2) / len;
    cx  = (tx < 0) ? -longint'(qx) : longint'(qx);
    cy  = (ty < 0) ? -longint'(qy) : longint'(qy);
    if (side_reg == 1'b0) begin
      ox = px + cy;
      oy = py - cx;
    end else begin
      ox = px - cy;
      oy = py + cx;
    end
    r.off_x = clamp_coord(ox);
    r.off_y = clamp_coord(oy);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    longint         px, py;
    offset_result_t got, want;
    if (rst) begin
      width_reg  = TW_RESET;
      side_reg   = 1'b0;
      held_count = PS_NONE;
      held_x = 0; held_y = 0; back_x = 0; back_y = 0;
      expected_offsets.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OFFSET_WIDTH) width_reg = cfg_data;
        else                               side_reg  = cfg_data[0];
      end

      // results leave before this edge's item can add any
      if (out_valid && out_ready) begin
        got = '{offset_x, offset_y, dropped, end_of_lane};
        results_seen++;
        if (dropped) drops_seen++;
        if (expected_offsets.size() == 0) begin
          $error("result with nothing expected: offset_x %0d offset_y %0d dropped %0b",
                 $signed(offset_x), $signed(offset_y), dropped);
          mismatch_count++;
        end else begin
          want = expected_offsets.pop_front();
          if (got.off_x !== want.off_x) begin
            $error("offset_x: expected %0d, got %0d", $signed(want.off_x), $signed(got.off_x));
            mismatch_count++;
          end
          if (got.off_y !== want.off_y) begin
            $error("offset_y: expected %0d, got %0d", $signed(want.off_y), $signed(got.off_y));
            mismatch_count++;
          end
          if (got.drop !== want.drop) begin
            $error("dropped: expected %0b, got %0b", want.drop, got.drop);
            mismatch_count++;
          end
          if (got.eol !== want.eol) begin
            $error("end_of_lane: expected %0b, got %0b", want.eol, got.eol);
            mismatch_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        px = $signed(point_x);
        py = $signed(point_y);
        if (held_count == PS_NONE) begin
          if (final_point) begin
            add_expected('{'0, '0, 1'b1, 1'b1});
          end else begin
            held_x     = px;
            held_y     = py;
            held_count = PS_ONE;
          end
        end else begin
          // one-sided tangent for the first point, central after that
          if (held_count == PS_ONE)
            add_expected(offset_along_normal(held_x, held_y,
                         px - held_x, py - held_y, 1'b0));
          else
            add_expected(offset_along_normal(held_x, held_y,
                         px - back_x, py - back_y, 1'b0));
          if (final_point) begin
            add_expected(offset_along_normal(px, py,
                         px - held_x, py - held_y, 1'b1));
            held_count = PS_NONE;
          end else begin
            back_x     = held_x;
            back_y     = held_y;
            held_x     = px;
            held_y     = py;
            held_count = PS_MANY;
          end
        end
      end
    end
    pending_results = expected_offsets.size();
  end

endmodule

// ----- tb/polyline_normal_offset_unit_test.sv -----
// ----------------------------------------------------------------------------
// polyline normal offset unit - testbench top
// drives lane polylines into the unit under several track width and side
// settings, with random gaps on both channels, and gives the verdict from
// the checker's mismatch count
// ----------------------------------------------------------------------------
module polyline_normal_offset_unit_test;

  import pno_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 144;
  // a point that makes no result does not keep the sequencer busy
  localparam int SETTLE_CYCLES     = 200;
  localparam int TAIL_CYCLES       = 200;

  // register settings per phase; phase 0 runs on reset values
  localparam logic [TW_W-1:0] WIDTH_PLAN [NUM_SETTINGS] =
    '{TW_RESET, 21'd0, 21'd1048576, 21'd2097151, 21'd1, 21'd0, 21'd229376, 21'd0};
  localparam logic            SIDE_PLAN  [NUM_SETTINGS] =
    '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  // shapes of random polylines
  typedef enum int {PATH_WALK, PATH_WILD, PATH_EDGE, PATH_STUTTER} path_style_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [TW_W-1:0]    cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic               final_point;
  logic               out_valid;
  logic               out_ready;
  logic [COORD_W-1:0] offset_x;
  logic [COORD_W-1:0] offset_y;
  logic               dropped;
  logic               end_of_lane;

  int mismatch_count, pending_results, results_seen, drops_seen;
  int points_sent, lanes_sent, settings_used;

  // receiver side: stall bursts, with calm stretches that never stall
  int stall_left;
  bit rx_calm;

  polyline_normal_offset_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .final_point (final_point),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .offset_x    (offset_x),
    .offset_y    (offset_y),
    .dropped     (dropped),
    .end_of_lane (end_of_lane)
  );

  polyline_normal_offset_unit_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .point_x         (point_x),
    .point_y         (point_y),
    .final_point     (final_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .offset_x        (offset_x),
    .offset_y        (offset_y),
    .dropped         (dropped),
    .end_of_lane     (end_of_lane),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_seen    (results_seen),
    .drops_seen      (drops_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(8, 60);
  endfunction

  // coordinate at or near either end of the range, near zero, or anywhere
  function automatic logic [COORD_W-1:0] edge_coord();
    logic [COORD_W-1:0] nudge;
    nudge = $urandom_range(0, 1 << 20);
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF - nudge;
      1:       return 32'h8000_0000 + nudge;
      2:       return nudge - 32'd524288;
      3:       return $urandom;
      4:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // receiver: out_ready changes on falling edges only
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = 1 + idle_cycles();
    end
  end

  // one point item; valid stays up across back-to-back items
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic fin, input bit calm);
    int gap;
    gap = calm ? 0 : idle_cycles();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid    = 1'b1;
    point_x     = x;
    point_y     = y;
    final_point = fin;
    do @(posedge clk); while (!in_ready);
    points_sent++;
    if (fin) lanes_sent++;
  endtask

  task automatic write_register(input logic idx, input logic [TW_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // sender holds off until every expected offset has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  // random polyline; mostly smooth lanes, some noise and degenerate shapes
  task automatic run_polyline();
    int                 n, r;
    path_style_t        style;
    bit                 calm;
    longint             cx, cy, sx, sy;
    logic [COORD_W-1:0] x, y, x1, y1, x2, y2;
    r = $urandom_range(0, 99);
    if (r < 8)       n = 1;
    else if (r < 20) n = 2;
    else if (r < 85) n = $urandom_range(3, 12);
    else             n = $urandom_range(13, 40);
    r = $urandom_range(0, 99);
    if (r < 55)      style = PATH_WALK;
    else if (r < 70) style = PATH_WILD;
    else if (r < 82) style = PATH_EDGE;
    else             style = PATH_STUTTER;
    calm = ($urandom_range(0, 4) == 0);
    cx = longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000;
    cy = longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000;
    sx = longint'($urandom_range(1, 1 << 20));
    if ($urandom_range(0, 3) == 0) sx = -sx;
    sy = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    x1 = COORD_W'(cx);
    y1 = COORD_W'(cy);
    x2 = x1;
    y2 = y1;
    for (int k = 0; k < n; k++) begin
      // lane walk steps by default, styles below may override the point
      x  = COORD_W'(cx);
      y  = COORD_W'(cy);
      cx = cx + sx + longint'($urandom_range(0, 4096)) - 2048;
      cy = cy + sy + longint'($urandom_range(0, 4096)) - 2048;
      case (style)
        PATH_WILD: begin
          x = $urandom;
          y = $urandom;
        end
        PATH_EDGE: begin
          x = edge_coord();
          y = edge_coord();
        end
        PATH_STUTTER: begin
          r = $urandom_range(0, 99);
          if (r < 35) begin
            // repeated point, zero one-sided tangent
            x = x1; y = y1;
          end else if (r < 55) begin
            // back to the point two before, zero central tangent
            x = x2; y = y2;
          end else if (r < 75) begin
            // one lsb step
            x = x1 + COORD_W'($urandom_range(0, 1));
            y = y1 - COORD_W'($urandom_range(0, 1));
          end
        end
        default: ;
      endcase
      send_point(x, y, k == n - 1, calm);
      x2 = x1; y2 = y1;
      x1 = x;  y1 = y;
    end
  endtask

  initial begin
    logic [TW_W-1:0] width;
    int              target;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_OFFSET_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    point_x     = '0;
    point_y     = '0;
    final_point = 1'b0;
    out_ready   = 1'b0;
    stall_left  = 0;
    rx_calm     = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph == 0) begin
        // directed lanes under reset values (3.5 m, left lane)
        // single point list gives one dropped result
        send_point(32'h1234_0000, 32'h0005_0000, 1'b1, 1'b0);
        // two point list, one-sided tangent at both ends
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        send_point(32'h0001_0000, 32'h0000_0000, 1'b1, 1'b0);
        // all points equal, every tangent zero
        send_point(32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0);
        send_point(32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0);
        send_point(32'h0000_0005, 32'h0000_0005, 1'b1, 1'b0);
        // out and back, zero central difference in the middle only
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        // corners of the range, widest tangents and saturated sums
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        // one lsb tangents, largest upward scaling
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
        send_point(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0);
        send_point(32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0);
        // offset pushes x past the top, then past the bottom
        send_point(32'h7FFF_FFF0, 32'h0000_0000, 1'b0, 1'b0);
        send_point(32'h7FFF_FFF0, 32'h0001_0000, 1'b1, 1'b0);
        send_point(32'h8000_0010, 32'h0000_0000, 1'b0, 1'b0);
        send_point(32'h8000_0010, 32'hFFFF_0000, 1'b1, 1'b0);
      end else begin
        // registers change only with nothing in flight
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        width = WIDTH_PLAN[ph];
        if (ph == 5 || ph == 7) width = $urandom_range(0, 1048576);
        write_register(CFG_OFFSET_WIDTH, width);
        write_register(CFG_LANE_SIDE, SIDE_PLAN[ph]);
      end
      settings_used++;
      target = points_sent + ITEMS_PER_SETTING;
      while (points_sent < target) begin
        run_polyline();
        if ($urandom_range(0, 11) == 0) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("run covered %0d point items in %0d polylines over %0d register settings",
             points_sent, lanes_sent, settings_used);
    $display("%0d offset results checked, %0d of them dropped", results_seen, drops_seen);
    if (mismatch_count == 0) begin
      $display("polyline_normal_offset_unit_test passed");
    end else begin
      $display("polyline_normal_offset_unit_test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("polyline_normal_offset_unit_test failed");
    $finish;
  end

endmodule
